/* design/pngfi_pkg.sv */
package pngfi_pkg;

  // one input word: a stream byte and its start-of-stream mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_t;

  // one result word
  typedef struct packed {
    logic        status;
    logic [31:0] image_index;
    logic [31:0] image_offset;
    logic [31:0] image_size;
  } out_t;

  // result status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_BAD_SIG = 1'b1;

  // parse phase codes
  localparam logic [1:0] PH_SIG  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  // first byte offset that is never parsed; reaching it stops the stream
  localparam logic [31:0] POS_LIMIT = 32'hFFFF_FFFF;

  // crc field length that follows every chunk's data
  localparam logic [32:0] CRC_BYTES = 33'd4;

  // png file signature, one byte per position
  function automatic logic [7:0] sig_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // chunk type of the final chunk, "IEND"
  function automatic logic [7:0] end_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0: b = 8'h49;
      2'd1: b = 8'h45;
      2'd2: b = 8'h4E;
      2'd3: b = 8'h44;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* design/pngfi_parse.sv */
module pngfi_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  pngfi_pkg::in_t    word,
  output logic              res_valid,
  output pngfi_pkg::out_t   res
);
  import pngfi_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [2:0]  byte_in_field, byte_in_field_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [32:0] skip_remaining, skip_remaining_next;
  logic        type_is_end, type_is_end_next;
  logic [31:0] image_start, image_start_next;
  logic [31:0] position, position_next;
  logic        stopped, stopped_next;
  logic [31:0] image_count, image_count_next;

  // state as seen by this byte, after an optional stream restart
  logic [1:0]  cur_phase;
  logic [2:0]  cur_bif;
  logic [31:0] cur_len;
  logic [32:0] cur_skip;
  logic        cur_tie;
  logic [31:0] cur_start;
  logic [31:0] cur_pos;
  logic        cur_stopped;
  logic [31:0] cur_count;
  logic [32:0] skip_dec;
  logic        match;
  logic        hit;
  out_t        r;

  always_comb begin
    if (word.stream_start) begin
      cur_phase   = PH_SIG;
      cur_bif     = 3'd0;
      cur_len     = 32'd0;
      cur_skip    = 33'd0;
      cur_tie     = 1'b0;
      cur_start   = 32'd0;
      cur_pos     = 32'd0;
      cur_stopped = 1'b0;
      cur_count   = 32'd0;
    end else begin
      cur_phase   = phase;
      cur_bif     = byte_in_field;
      cur_len     = chunk_length;
      cur_skip    = skip_remaining;
      cur_tie     = type_is_end;
      cur_start   = image_start;
      cur_pos     = position;
      cur_stopped = stopped;
      cur_count   = image_count;
    end

    phase_next          = cur_phase;
    byte_in_field_next  = cur_bif;
    chunk_length_next   = cur_len;
    skip_remaining_next = cur_skip;
    type_is_end_next    = cur_tie;
    image_start_next    = cur_start;
    position_next       = cur_pos;
    stopped_next        = cur_stopped;
    image_count_next    = cur_count;
    hit                 = 1'b0;
    r.status            = STATUS_DONE;
    r.image_index       = cur_count;
    r.image_offset      = cur_start;
    r.image_size        = 32'd0;
    match               = 1'b0;
    skip_dec            = (cur_skip != 33'd0) ? cur_skip - 33'd1 : cur_skip;

    if (cur_stopped) begin
      // idle until a new stream
    end else if (cur_pos == POS_LIMIT) begin
      stopped_next = 1'b1;
    end else begin
      position_next = cur_pos + 32'd1;
      case (cur_phase)
        PH_SIG: begin
          match = (word.data_byte == sig_byte(cur_bif));
          if (cur_bif == 3'd0) begin
            image_start_next = cur_pos;
            type_is_end_next = match;
          end else begin
            type_is_end_next = cur_tie & match;
          end
          if (cur_bif == 3'd7) begin
            byte_in_field_next = 3'd0;
            if (!type_is_end_next) begin
              hit           = 1'b1;
              r.status      = STATUS_BAD_SIG;
              r.image_offset = image_start_next;
              stopped_next  = 1'b1;
              position_next = cur_pos;
            end else begin
              phase_next = PH_HDR;
            end
          end else begin
            byte_in_field_next = cur_bif + 3'd1;
          end
        end
        PH_HDR: begin
          match = (word.data_byte == end_byte(cur_bif[1:0]));
          if (!cur_bif[2]) begin
            chunk_length_next = {cur_len[23:0], word.data_byte};
          end else if (cur_bif == 3'd4) begin
            type_is_end_next = match;
          end else begin
            type_is_end_next = cur_tie & match;
          end
          if (cur_bif == 3'd7) begin
            byte_in_field_next  = 3'd0;
            skip_remaining_next = {1'b0, cur_len} + CRC_BYTES;
            phase_next          = PH_SKIP;
          end else begin
            byte_in_field_next = cur_bif + 3'd1;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 33'd0) begin
            if (cur_tie) begin
              hit              = 1'b1;
              r.status         = STATUS_DONE;
              r.image_size     = cur_pos - cur_start + 32'd1;
              image_count_next = cur_count + 32'd1;
              phase_next       = PH_SIG;
            end else begin
              phase_next = PH_HDR;
            end
            chunk_length_next  = 32'd0;
            type_is_end_next   = 1'b0;
            byte_in_field_next = 3'd0;
          end
        end
        default: begin
          // unused phase: byte ignored
          position_next = cur_pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIG;
      byte_in_field  <= 3'd0;
      chunk_length   <= 32'd0;
      skip_remaining <= 33'd0;
      type_is_end    <= 1'b0;
      image_start    <= 32'd0;
      position       <= 32'd0;
      stopped        <= 1'b0;
      image_count    <= 32'd0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_in_field  <= byte_in_field_next;
      chunk_length   <= chunk_length_next;
      skip_remaining <= skip_remaining_next;
      type_is_end    <= type_is_end_next;
      image_start    <= image_start_next;
      position       <= position_next;
      stopped        <= stopped_next;
      image_count    <= image_count_next;
    end
  end

  assign res_valid = accept & hit;
  assign res       = r;

endmodule

/* design/png_stream_frame_indexer.sv */
// png stream frame indexer: scans a byte stream of png images laid back to back,
// one byte word per clock unless byte_stall is high; reports each image's index,
// start offset and size when the last crc byte of its IEND chunk arrives. a bad
// signature yields one status=1 word and the block then drops bytes until a word
// with stream_start set. a word with stream_start clears all state and counts as
// offset 0. each result word is registered in the output register, or in the
// one-entry skid slot while a result waits there; the two slots let input bytes
// keep flowing while a result waits, so byte_stall rises only when both are full.
module png_stream_frame_indexer (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  pngfi_pkg::in_t   byte_word,
  output logic             result_valid,
  input  logic             result_stall,
  output pngfi_pkg::out_t  result_word
);
  import pngfi_pkg::*;

  logic  accept;
  logic  res_valid;
  out_t  res;
  logic  skid_valid;
  out_t  skid_word;
  logic  take;

  // input taken whenever the skid slot is free
  assign byte_stall = skid_valid;
  assign accept     = byte_valid & ~byte_stall;
  assign take       = result_valid & ~result_stall;

  pngfi_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .word      (byte_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      result_word <= skid_valid ? skid_word : res;
    end
    if (result_valid && !take && res_valid) begin
      skid_word <= res;
    end
  end

  // skid slot only fills behind a waiting result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid slot holds a word with empty output register");

  // no new result may arrive while both slots are full
  assert property (@(posedge clk) disable iff (rst) res_valid |-> !skid_valid)
    else $error("result produced with no free slot");

  // a bad signature result is not directly followed by another, unless a new stream starts
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STATUS_BAD_SIG) |=>
      (!res_valid || byte_word.stream_start))
    else $error("result after stream stop");

endmodule

/* tb/sv/tb_png_stream_frame_indexer.sv */
module tb_png_stream_frame_indexer;
  timeunit 1ns;
  timeprecision 1ps;

  import pngfi_pkg::*;

  // png signature and chunk type codes, most significant byte first
  localparam logic [63:0] PNG_SIG   = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] END_TYPE  = 32'h4945_4E44;
  localparam logic [31:0] DATA_TYPE = 32'h4944_4154;
  localparam logic [31:0] HDR_TYPE  = 32'h4948_4452;

  // cycles of the long result hold-off, and bytes of parsing work to generate
  localparam int LONG_HOLD = 600;
  localparam int MIN_WORK  = 1800;

  logic   clk;
  logic   rst;
  logic   byte_valid;
  logic   byte_stall;
  in_t    byte_word;
  logic   result_valid;
  logic   result_stall;
  out_t   result_word;

  // when set, the byte side inserts no gaps and the result side adds no new random stalls
  logic   calm = 1'b0;
  // long hold-off requests from the byte side, served by the result side
  int     holds_asked = 0;
  int     holds_served = 0;
  int     n_streams = 0;

  // bytes of the stream being built
  logic [7:0] sbuf[$];

  // tracks the parser state and keeps the frame results still to come
  class frame_scoreboard;
    logic [1:0]  phase;
    logic [2:0]  fld;
    logic [31:0] clen;
    logic [32:0] skip_left;
    logic        is_end;
    logic [31:0] img_start;
    logic [31:0] pos;
    logic [31:0] img_cnt;
    logic        stopped;
    out_t        expected_frames[$];
    int          errors;
    int          n_worked;
    int          n_done;
    int          n_bad;

    function new();
      clear();
      errors = 0;
      n_worked = 0;
      n_done = 0;
      n_bad = 0;
    endfunction

    function void clear();
      phase = PH_SIG;
      fld = 3'd0;
      clen = '0;
      skip_left = '0;
      is_end = 1'b0;
      img_start = '0;
      pos = '0;
      img_cnt = '0;
      stopped = 1'b0;
    endfunction

    function void push_result(logic st, logic [31:0] size);
      out_t r;
      r.status = st;
      r.image_index = img_cnt;
      r.image_offset = img_start;
      r.image_size = size;
      expected_frames.push_back(r);
    endfunction

    // advance the parser by one accepted byte word
    function void note_byte(in_t w);
      logic [7:0]  b;
      logic [31:0] here;
      logic        hit;
      b = w.data_byte;
      if (w.stream_start) clear();
      if (stopped) return;
      // the last offset is never parsed, the stream just stops
      if (pos == POS_LIMIT) begin
        stopped = 1'b1;
        return;
      end
      here = pos;
      n_worked++;
      case (phase)
        PH_SIG: begin
          hit = (b == PNG_SIG[63 - 8 * int'(fld) -: 8]);
          if (fld == 3'd0) begin
            img_start = here;
            is_end = hit;
          end else begin
            is_end = is_end & hit;
          end
          if (fld == 3'd7) begin
            fld = 3'd0;
            if (!is_end) begin
              push_result(STATUS_BAD_SIG, 32'd0);
              stopped = 1'b1;
              return;
            end
            phase = PH_HDR;
          end else begin
            fld = fld + 3'd1;
          end
        end
        PH_HDR: begin
          if (fld < 3'd4) begin
            clen = {clen[23:0], b};
          end else begin
            hit = (b == END_TYPE[31 - 8 * (int'(fld) - 4) -: 8]);
            is_end = (fld == 3'd4) ? hit : (is_end & hit);
          end
          if (fld == 3'd7) begin
            fld = 3'd0;
            skip_left = {1'b0, clen} + CRC_BYTES;
            phase = PH_SKIP;
          end else begin
            fld = fld + 3'd1;
          end
        end
        PH_SKIP: begin
          if (skip_left != '0) skip_left = skip_left - 33'd1;
          if (skip_left == '0) begin
            if (is_end) begin
              push_result(STATUS_DONE, here - img_start + 32'd1);
              img_cnt = img_cnt + 32'd1;
              phase = PH_SIG;
            end else begin
              phase = PH_HDR;
            end
            clen = '0;
            is_end = 1'b0;
            fld = 3'd0;
          end
        end
        default: return;
      endcase
      pos = here + 32'd1;
    endfunction

    function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got status %0d index %0d off %0h size %0d",
                 $time, got.status, got.image_index, got.image_offset, got.image_size);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("image_index", want.image_index, got.image_index);
      cmp_field("image_offset", want.image_offset, got.image_offset);
      cmp_field("image_size", want.image_size, got.image_size);
      if (want.status == STATUS_DONE) n_done++;
      else n_bad++;
    endfunction

    function void report_leftover();
      foreach (expected_frames[i]) begin
        $display("%0t ns: missing result, expected status %0d index %0d off %0h size %0d, got none",
                 $time, expected_frames[i].status, expected_frames[i].image_index,
                 expected_frames[i].image_offset, expected_frames[i].image_size);
        errors++;
      end
    endfunction
  endclass

  frame_scoreboard sb;

  png_stream_frame_indexer DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stream building
  // ---------------------------------------------------------------------------

  // png signature, with one byte damaged when bad_at is 0..7
  function automatic void add_sig(int bad_at);
    logic [7:0] b;
    for (int k = 0; k < 8; k++) begin
      b = PNG_SIG[63 - 8 * k -: 8];
      if (k == bad_at) b = b ^ 8'($urandom_range(1, 255));
      sbuf.push_back(b);
    end
  endfunction

  // chunk header: big-endian length then type
  function automatic void add_header(logic [31:0] len, logic [31:0] ty);
    for (int k = 3; k >= 0; k--) sbuf.push_back(len[8 * k +: 8]);
    for (int k = 3; k >= 0; k--) sbuf.push_back(ty[8 * k +: 8]);
  endfunction

  // whole chunk: header, random data and random crc
  function automatic void add_chunk(logic [31:0] len, logic [31:0] ty);
    add_header(len, ty);
    repeat (len + 4) sbuf.push_back(8'($urandom));
  endfunction

  // mostly short chunks so images stay small
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  // ordinary type, random type, or IEND with one byte off
  function automatic logic [31:0] rand_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return DATA_TYPE;
    if (r < 75) return $urandom();
    return END_TYPE ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
  endfunction

  function automatic void add_image();
    add_sig(8);
    repeat ($urandom_range(0, 3)) add_chunk(rand_len(), rand_type());
    add_chunk(rand_len(), END_TYPE);
  endfunction

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_byte(logic [7:0] b, logic s);
    int   gap;
    in_t  w;
    w.data_byte = b;
    w.stream_start = s;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word <= w;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_byte(w);
  endtask

  // send the first keep bytes of the built stream, then drop it
  task automatic flush_stream(logic first, int keep);
    for (int i = 0; i < keep; i++) send_byte(sbuf[i], (i == 0) ? first : 1'b0);
    sbuf.delete();
  endtask

  // stop offering and let every pending result come out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_frames.size() != 0) @(posedge clk);
  endtask

  // one random stream: mostly whole images, some ending in a bad
  // signature, a cut-off image or a chunk with a huge length
  task automatic random_stream();
    int   kind;
    int   n_img;
    int   base;
    int   cut;
    logic first;
    kind = $urandom_range(0, 99);
    n_img = $urandom_range(1, 3);
    calm = ($urandom_range(0, 99) < 15);
    // a few streams carry on without the start mark
    first = ($urandom_range(0, 99) < 85);
    for (int i = 0; i < n_img - 1; i++) add_image();
    base = sbuf.size();
    if (kind < 65) begin
      add_image();
    end else if (kind < 80) begin
      add_sig($urandom_range(0, 7));
      repeat ($urandom_range(0, 5)) sbuf.push_back(8'($urandom));
    end else if (kind < 92) begin
      add_image();
    end else begin
      add_sig(8);
      add_header($urandom(), DATA_TYPE);
      repeat ($urandom_range(0, 16)) sbuf.push_back(8'($urandom));
    end
    cut = sbuf.size();
    if (kind >= 80 && kind < 92) cut = $urandom_range(base + 1, sbuf.size() - 1);
    flush_stream(first, cut);
    n_streams++;
  endtask

  initial begin : byte_side
    int spins;
    sb = new();
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_word <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest legal image right out of reset, no start mark needed
    add_sig(8);
    add_chunk(0, END_TYPE);
    flush_stream(1'b0, sbuf.size());
    // bad last signature byte straight after, then bytes that are dropped
    add_sig(7);
    sbuf.push_back(8'hFF);
    sbuf.push_back(8'h00);
    flush_stream(1'b0, sbuf.size());
    // restart with an all-ones chunk length, cut short by the next restart
    add_sig(8);
    add_header(32'hFFFF_FFFF, END_TYPE);
    sbuf.push_back(8'h00);
    sbuf.push_back(8'hFF);
    flush_stream(1'b1, sbuf.size());
    // restart that ends inside the signature
    add_sig(8);
    flush_stream(1'b1, 3);
    // near-miss type, a short chunk, then the end chunk
    add_sig(8);
    add_chunk(0, END_TYPE ^ 32'h0000_0001);
    add_chunk(3, HDR_TYPE);
    add_chunk(0, END_TYPE);
    flush_stream(1'b1, sbuf.size());
    // bad first signature byte
    add_sig(0);
    flush_stream(1'b1, sbuf.size());

    // pause until the directed results are all back
    wait_drained();

    // long result hold-offs, at the start and after 30 streams, while bytes keep coming
    holds_asked++;
    while (sb.n_worked < MIN_WORK) begin
      random_stream();
      if (n_streams == 30) holds_asked++;
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
    calm = 1'b0;

    // drain, then keep watching for anything stray before the leftover report
    byte_valid <= 1'b0;
    @(posedge clk);
    spins = 0;
    while (sb.expected_frames.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (20) @(posedge clk);
    sb.report_leftover();

    $display("covered %0d parsed bytes over %0d random streams plus directed cases",
             sb.n_worked, n_streams);
    $display("checked %0d finished images and %0d bad signatures", sb.n_done, sb.n_bad);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  initial begin : result_side
    int hold;
    int r;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      // values seen here are the ones from just before the edge
      if (!rst && result_valid && !result_stall) sb.check_result(result_word);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        result_stall <= 1'b1;
      end else if (calm) begin
        result_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          result_stall <= 1'b0;
        end else begin
          // stall now, with hold set to the further stall cycles, which may be none
          hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
          result_stall <= 1'b1;
        end
      end
    end
  end

endmodule
